FILE: rtl/owsm_pkg.sv
// shared constants, widths and types of the three-wheel speed mixer
`default_nettype none

package owsm_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int IN_W       = 16;
  localparam int WHEEL_W    = 10;
  localparam int LIM_W      = 7;
  localparam int COEF_W     = 19;
  localparam int VW         = IN_W + COEF_W;
  localparam int MAG_W      = VW - 1;
  localparam int PW         = MAG_W + LIM_W;
  localparam int QB         = WHEEL_W;
  localparam int RW         = MAG_W + QB + 1;
  localparam int CMP_W      = VW + LIM_W;
  localparam int UNIT_SHIFT = FRAC_BITS + 16;
  localparam int BIT_CNT_W  = $clog2(IN_W);
  localparam int DIV_CNT_W  = $clog2(QB);
  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 32;
  localparam int TUSER_OUT_W = 2;

  // mixing coefficients in signed q2.16
  localparam logic signed [COEF_W-1:0] C_ONE   = 19'sd65536;
  localparam logic signed [COEF_W-1:0] C_HALF  = 19'sd32768;
  localparam logic signed [COEF_W-1:0] C_SIN60 = 19'sd56756;
  localparam logic signed [COEF_W-1:0] C_ZERO  = 19'sd0;

  localparam logic [MAG_W-1:0] UNIT_DEN = MAG_W'(1) << UNIT_SHIFT;

  // register indexes
  localparam logic CFG_DRIVE = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd50;

  typedef logic signed [VW-1:0] mix_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [LIM_W-1:0] mult;
    logic [MAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QB-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/owsm_mix.sv
// bit-serial mixer: body velocity to three raw wheel speeds, msb first
`default_nettype none

module owsm_mix (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [owsm_pkg::IN_W-1:0] vel_x,
  input  logic [owsm_pkg::IN_W-1:0] vel_y,
  input  logic [owsm_pkg::IN_W-1:0] vel_rot,
  output logic                     done,
  output owsm_pkg::mix_t           mix_front,
  output owsm_pkg::mix_t           mix_left_rear,
  output owsm_pkg::mix_t           mix_right_rear
);

  import owsm_pkg::*;

  logic                 busy;
  logic [BIT_CNT_W-1:0] cnt;
  logic [IN_W-1:0]      sx;
  logic [IN_W-1:0]      sy;
  logic [IN_W-1:0]      sr;
  mix_t                 acc0;
  mix_t                 acc1;
  mix_t                 acc2;
  logic signed [COEF_W-1:0] c0;
  logic signed [COEF_W-1:0] c1;
  logic signed [COEF_W-1:0] c2;
  mix_t                 e0;
  mix_t                 e1;
  mix_t                 e2;
  logic                 first;
  logic                 bx;
  logic                 by;
  logic                 br;

  always_comb begin
    bx    = sx[IN_W-1];
    by    = sy[IN_W-1];
    br    = sr[IN_W-1];
    first = (cnt == '0);
    c0 = (bx ? C_ONE : C_ZERO) + (br ? C_ONE : C_ZERO);
    c1 = (bx ? -C_HALF : C_ZERO) + (by ? C_SIN60 : C_ZERO) + (br ? C_ONE : C_ZERO);
    c2 = (bx ? -C_HALF : C_ZERO) - (by ? C_SIN60 : C_ZERO) + (br ? C_ONE : C_ZERO);
    // sign bit carries negative weight
    e0 = first ? -mix_t'(c0) : mix_t'(c0);
    e1 = first ? -mix_t'(c1) : mix_t'(c1);
    e2 = first ? -mix_t'(c2) : mix_t'(c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == BIT_CNT_W'(IN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sx   <= vel_x;
      sy   <= vel_y;
      sr   <= vel_rot;
      acc0 <= '0;
      acc1 <= '0;
      acc2 <= '0;
    end else if (busy) begin
      sx   <= {sx[IN_W-2:0], 1'b0};
      sy   <= {sy[IN_W-2:0], 1'b0};
      sr   <= {sr[IN_W-2:0], 1'b0};
      acc0 <= (acc0 <<< 1) + e0;
      acc1 <= (acc1 <<< 1) + e1;
      acc2 <= (acc2 <<< 1) + e2;
    end
  end

  assign mix_front      = acc0;
  assign mix_left_rear  = acc1;
  assign mix_right_rear = acc2;

endmodule

`default_nettype wire

FILE: rtl/owsm_div.sv
// serial multiply then restoring divide with rounding and saturation at 512
`default_nettype none

module owsm_div (
  input  logic               clk,
  input  logic               rst,
  input  owsm_pkg::div_req_t req,
  output owsm_pkg::div_rsp_t rsp
);

  import owsm_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_LOAD = 2'd2;
  localparam logic [1:0] D_DIV  = 2'd3;

  logic [1:0]           phase;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [MAG_W-1:0]     mag_r;
  logic [MAG_W-1:0]     den_r;
  logic [LIM_W-1:0]     mul_sh;
  logic [PW-1:0]        prod;
  logic [RW-1:0]        rem;
  logic [RW-1:0]        dsh;
  logic [QB-1:0]        quo;
  logic                 ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        D_IDLE: begin
          if (req.start) begin
            phase <= D_MUL;
            cnt   <= '0;
          end
        end
        D_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(LIM_W - 1)) begin
            phase <= D_LOAD;
          end
        end
        D_LOAD: begin
          phase <= D_DIV;
          cnt   <= '0;
        end
        D_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(QB - 1)) begin
            phase <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      D_IDLE: begin
        if (req.start) begin
          mag_r  <= req.mag;
          den_r  <= req.den;
          mul_sh <= req.mult;
          prod   <= '0;
        end
      end
      D_MUL: begin
        prod   <= {prod[PW-2:0], 1'b0} + (mul_sh[LIM_W-1] ? PW'(mag_r) : '0);
        mul_sh <= {mul_sh[LIM_W-2:0], 1'b0};
      end
      D_LOAD: begin
        // numerator 2*a*mult + den over divisor 2*den gives round half up
        rem <= RW'({prod, 1'b0}) + RW'(den_r);
        dsh <= RW'(den_r) << QB;
        quo <= '0;
      end
      D_DIV: begin
        rem <= ge ? rem - dsh : rem;
        dsh <= dsh >> 1;
        quo <= {quo[QB-2:0], ge};
      end
      default: ;
    endcase
  end

  assign rsp.busy = (phase != D_IDLE);
  assign rsp.done = done;
  assign rsp.quo  = quo[QB-1] ? {1'b1, {(QB-1){1'b0}}} : quo;

`ifndef SYNTHESIS
  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("divider started while busy");
  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    req.start |=> rsp.busy)
    else $error("divider did not take start");
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !rsp.busy && $past(phase == D_DIV))
    else $error("divider done outside final step");
`endif

endmodule

`default_nettype wire

FILE: rtl/omni_three_wheel_speed_mixer.sv
// top level: three-wheel omni speed mixer with limit scaling and rounding
// the path from input to result valid runs through the bit-serial mixer and one shared
//   multiply-divide unit used per wheel
// drive disabled: no mixing or division; the held targets are registered to the output with motors_on low
// a new input transaction is taken only once the previous result has been loaded into the output register
// reset: synchronous, clears held targets to zero, drive off, speed limit 50
`default_nettype none

module omni_three_wheel_speed_mixer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [owsm_pkg::LIM_W-1:0]        cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // vel_x, vel_y, vel_rot
  input  logic [owsm_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // wheel_front, wheel_left_rear, wheel_right_rear, zero pad
  output logic [owsm_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  // motors_on, was_scaled
  output logic [owsm_pkg::TUSER_OUT_W-1:0]  m_axis_tuser
);

  import owsm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIX  = 3'd1;
  localparam logic [2:0] S_MAX1 = 3'd2;
  localparam logic [2:0] S_MAX2 = 3'd3;
  localparam logic [2:0] S_LIM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [WHEEL_W-1:0] WHEEL_MAX = {1'b0, {(WHEEL_W-1){1'b1}}};

  logic [2:0]         state;
  logic               drive_enabled;
  logic [LIM_W-1:0]   speed_limit;
  logic [1:0]         k;
  logic [WHEEL_W-1:0] tgt [3];
  mix_t               m_r;
  logic               scaled;
  logic               neg_r;
  logic [WHEEL_W-1:0] out_front;
  logic [WHEEL_W-1:0] out_left;
  logic [WHEEL_W-1:0] out_right;
  logic               out_motors;
  logic               out_scaled;
  logic               out_free;
  logic               accept;
  logic               mix_start;
  logic               mix_done;
  mix_t               v [3];
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  mix_t               vk;
  logic [WHEEL_W-1:0] wheel_val;
  logic signed [CMP_W-1:0] m_wide;
  logic signed [CMP_W-1:0] lim_wide;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mix_start     = accept && drive_enabled;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  owsm_mix u_mix (
    .clk            (clk),
    .rst            (rst),
    .start          (mix_start),
    .vel_x          (s_axis_tdata[IN_W-1:0]),
    .vel_y          (s_axis_tdata[2*IN_W-1:IN_W]),
    .vel_rot        (s_axis_tdata[3*IN_W-1:2*IN_W]),
    .done           (mix_done),
    .mix_front      (v[0]),
    .mix_left_rear  (v[1]),
    .mix_right_rear (v[2])
  );

  owsm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    vk             = v[k];
    div_req.start  = (state == S_DIV);
    div_req.mag    = MAG_W'(vk[VW-1] ? -vk : vk);
    div_req.mult   = scaled ? speed_limit : LIM_W'(1);
    div_req.den    = scaled ? MAG_W'(m_r) : UNIT_DEN;
    m_wide         = CMP_W'(m_r);
    lim_wide       = $signed(CMP_W'(speed_limit) << UNIT_SHIFT);
    if (neg_r) begin
      wheel_val = -div_rsp.quo;
    end else if (div_rsp.quo[QB-1]) begin
      wheel_val = WHEEL_MAX;
    end else begin
      wheel_val = div_rsp.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      drive_enabled <= 1'b0;
      speed_limit   <= LIMIT_RESET;
      k             <= '0;
      tgt[0]        <= '0;
      tgt[1]        <= '0;
      tgt[2]        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DRIVE: drive_enabled <= cfg_data[0];
          CFG_LIMIT: speed_limit   <= cfg_data;
          default:   ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= drive_enabled ? S_MIX : S_DONE;
          end
        end
        S_MIX: begin
          if (mix_done) begin
            state <= S_MAX1;
          end
        end
        S_MAX1: state <= S_MAX2;
        S_MAX2: state <= S_LIM;
        S_LIM: begin
          state <= S_DIV;
          k     <= '0;
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (div_rsp.done) begin
            tgt[k] <= wheel_val;
            if (k == 2'd2) begin
              state <= S_DONE;
            end else begin
              k     <= k + 1'b1;
              state <= S_DIV;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          scaled <= 1'b0;
        end
      end
      S_MAX1: m_r    <= (v[1] > v[0]) ? v[1] : v[0];
      S_MAX2: m_r    <= (v[2] > m_r) ? v[2] : m_r;
      S_LIM:  scaled <= (m_wide > lim_wide);
      S_DIV:  neg_r  <= vk[VW-1];
      S_DONE: begin
        if (out_free) begin
          out_front  <= tgt[0];
          out_left   <= tgt[1];
          out_right  <= tgt[2];
          out_motors <= drive_enabled;
          out_scaled <= scaled;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {(TDATA_OUT_W - 3*WHEEL_W)'(0), out_right, out_left, out_front};
  assign m_axis_tuser = {out_scaled, out_motors};

`ifndef SYNTHESIS
  a_scaled_needs_drive : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("scaled flag set with drive off");
  a_wait_has_divider : assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> div_rsp.busy || div_rsp.done)
    else $error("waiting on an idle divider");
  a_idle_divider_free : assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("input ready while divider busy");
`endif

endmodule

`default_nettype wire
